// ===== sv/binary_line_run_extractor_unit_defines.svh =====
// Assertion macros for the binary line run extractor.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BINARY_LINE_RUN_EXTRACTOR_UNIT_DEFINES_SVH
`define BINARY_LINE_RUN_EXTRACTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property while out of reset
`define BLRE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("blre check failed");
// Check a property at every edge, reset included
`define BLRE_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("blre reset check failed");
`else
`define BLRE_ASSERT(lbl, clk, rst, prop)
`define BLRE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== sv/blre_pkg.sv =====
// Shared types, constants and helpers of the binary line run extractor.
// No dependencies; used by blre_rsp_if and all modules but the line store.
package blre_pkg;

   localparam int OUT_W          = 10;
   localparam int CFG_W          = 11;
   localparam int IDX_W          = 2;
   localparam int MODE_W         = 2;
   localparam int LAST_W         = 12;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam logic [CFG_W-1:0] SIZE_RST = 11'd1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_HORIZ      = 2'd0,
      MODE_VERT       = 2'd1,
      MODE_DIAG_RIGHT = 2'd2,
      MODE_DIAG_LEFT  = 2'd3
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_MODE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // Flags of the pixel held in the working register
   typedef struct packed {
      logic pixel;
      logic last_col;
      logic last_row;
   } pix_ctl_type;

   // Control decisions of one pixel step
   typedef struct packed {
      logic emit;
      logic store_we;
      logic store_active;
      logic row_active;
   } step_ctl_type;

   // Last valid index for a size register: zero counts as one, above max as max
   function automatic logic [LAST_W-1:0] last_index(input logic [CFG_W-1:0] v,
                                                    input int unsigned maxv);
      int unsigned t;
      if (v == '0) begin
         t = 0;
      end else if (32'(v) > maxv) begin
         t = maxv - 1;
      end else begin
         t = 32'(v) - 1;
      end
      return LAST_W'(t);
   endfunction

endpackage

// ===== sv/blre_ifs.sv =====
// Valid/ready channel interfaces for pixel beats and run result beats.
// Depends on blre_pkg for the result field width.
interface blre_req_if;
   logic valid;
   logic ready;
   logic pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface blre_rsp_if;
   import blre_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] start_row;
   logic [OUT_W-1:0] start_col;
   logic [OUT_W-1:0] end_row;
   logic [OUT_W-1:0] end_col;
   modport source (output valid, output start_row, output start_col, output end_row,
                   output end_col, input ready);
   modport sink (input valid, input start_row, input start_col, input end_row,
                 input end_col, output ready);
endinterface

// ===== sv/blre_line_store.sv =====
// Per-column line store with registered read, write forwarding and a
// clearing sweep after reset. Depends on nothing but its parameters.
module blre_line_store #(
   parameter int DEPTH = 1024,
   parameter int DW    = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data,
   output logic                     clear_busy
);
   localparam int AW = $clog2(DEPTH);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;
   logic [AW-1:0] clear_addr_ff;
   logic          clear_busy_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;

   // Sweep every entry to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clear_busy_ff <= 1'b0;
         end
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // Select between the sweep and the pixel write
   always_comb begin
      mem_we    = clear_busy_ff || wr_en;
      mem_waddr = clear_busy_ff ? clear_addr_ff : wr_addr;
      mem_wdata = clear_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Registered read; forward a write to the same entry in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ===== sv/blre_run_logic.sv =====
// Step logic for one pixel: run tracking in all four directions and the
// run result. Depends on blre_pkg.
module blre_run_logic #(
   parameter int CW = 10,
   parameter int RW = 10
) (
   input  blre_pkg::mode_type            mode,
   input  blre_pkg::pix_ctl_type         pix_ctl,
   input  logic [RW-1:0]                 row,
   input  logic [CW-1:0]                 col,
   input  logic                          rd_active,
   input  logic [RW-1:0]                 rd_start,
   input  logic                          hold_active,
   input  logic [RW-1:0]                 hold_start,
   input  logic                          row_active,
   input  logic [CW-1:0]                 row_start,
   output blre_pkg::step_ctl_type        step_ctl,
   output logic [RW-1:0]                 store_start,
   output logic [CW-1:0]                 row_start_in,
   output logic [blre_pkg::OUT_W-1:0]    start_row,
   output logic [blre_pkg::OUT_W-1:0]    start_col,
   output logic [blre_pkg::OUT_W-1:0]    end_row,
   output logic [blre_pkg::OUT_W-1:0]    end_col
);
   import blre_pkg::*;

   localparam int XW0 = (CW > RW) ? CW : RW;
   localparam int XW  = (XW0 > OUT_W) ? XW0 : OUT_W;

   logic          ra;
   logic [CW-1:0] rs;
   logic          in_act;
   logic [RW-1:0] in_st;
   logic          edge_hit;
   logic [RW-1:0] st;
   logic [XW-1:0] cx;
   logic [XW-1:0] rx;
   logic [XW-1:0] ecx;
   logic [XW-1:0] dx;
   logic [XW-1:0] sr_x;
   logic [XW-1:0] sc_x;
   logic [XW-1:0] er_x;
   logic [XW-1:0] ec_x;

   always_comb begin
      step_ctl     = '0;
      store_start  = '0;
      ra           = row_active;
      rs           = row_start;
      in_act       = 1'b0;
      in_st        = rd_start;
      edge_hit     = 1'b0;
      st           = row;
      cx           = XW'(col);
      rx           = XW'(row);
      ecx          = cx;
      dx           = '0;
      sr_x         = '0;
      sc_x         = '0;
      er_x         = '0;
      ec_x         = '0;

      if (mode == MODE_HORIZ) begin
         // Horizontal: drop an open run at the row start
         if (col == '0) begin
            ra = 1'b0;
         end
         if (pix_ctl.pixel) begin
            if (!ra) begin
               ra = 1'b1;
               rs = col;
            end
            if (pix_ctl.last_col) begin
               if (rs < col) begin
                  step_ctl.emit = 1'b1;
                  sr_x = rx;
                  sc_x = XW'(rs);
                  er_x = rx;
                  ec_x = cx;
               end
               ra = 1'b0;
            end
         end else begin
            if (ra && ((XW'(rs) + 1'b1) < cx)) begin
               step_ctl.emit = 1'b1;
               sr_x = rx;
               sc_x = XW'(rs);
               er_x = rx;
               ec_x = cx - 1'b1;
            end
            ra = 1'b0;
         end
      end else begin
         // Pick the incoming run from the line store or the diagonal hold
         case (mode)
            MODE_VERT: begin
               in_act   = (row != '0) && rd_active;
               in_st    = rd_start;
               edge_hit = pix_ctl.last_row;
            end
            MODE_DIAG_RIGHT: begin
               in_act   = (row != '0) && (col != '0) && hold_active;
               in_st    = hold_start;
               edge_hit = pix_ctl.last_row || pix_ctl.last_col;
            end
            MODE_DIAG_LEFT: begin
               in_act   = (row != '0) && !pix_ctl.last_col && rd_active;
               in_st    = pix_ctl.last_col ? '0 : rd_start;
               edge_hit = pix_ctl.last_row || (col == '0);
            end
            default: begin
               in_act   = 1'b0;
               in_st    = rd_start;
               edge_hit = 1'b0;
            end
         endcase

         step_ctl.store_we = 1'b1;
         if (pix_ctl.pixel) begin
            st = in_act ? in_st : row;
            if (edge_hit) begin
               // Run ends on its own pixel at the image edge
               if (st < row) begin
                  step_ctl.emit = 1'b1;
                  dx   = rx - XW'(st);
                  sr_x = XW'(st);
                  er_x = rx;
                  ec_x = cx;
                  if (mode == MODE_DIAG_RIGHT) begin
                     sc_x = cx - dx;
                  end else if (mode == MODE_DIAG_LEFT) begin
                     sc_x = cx + dx;
                  end else begin
                     sc_x = cx;
                  end
               end
            end else begin
               step_ctl.store_active = 1'b1;
               store_start           = st;
            end
         end else begin
            // Zero pixel closes the run that reached it
            store_start = in_st;
            if (in_act && ((XW'(in_st) + 1'b1) < rx)) begin
               step_ctl.emit = 1'b1;
               er_x = rx - 1'b1;
               if (mode == MODE_DIAG_RIGHT) begin
                  ecx = cx - 1'b1;
               end else if (mode == MODE_DIAG_LEFT) begin
                  ecx = cx + 1'b1;
               end else begin
                  ecx = cx;
               end
               dx   = er_x - XW'(in_st);
               sr_x = XW'(in_st);
               ec_x = ecx;
               if (mode == MODE_DIAG_RIGHT) begin
                  sc_x = ecx - dx;
               end else if (mode == MODE_DIAG_LEFT) begin
                  sc_x = ecx + dx;
               end else begin
                  sc_x = ecx;
               end
            end
         end
      end

      step_ctl.row_active = ra;
      row_start_in        = rs;
      start_row           = sr_x[OUT_W-1:0];
      start_col           = sc_x[OUT_W-1:0];
      end_row             = er_x[OUT_W-1:0];
      end_col             = ec_x[OUT_W-1:0];
   end

endmodule

// ===== sv/binary_line_run_extractor_unit.sv =====
// Top level of the binary line run extractor: config registers, pixel
// counters, working register, result register. Depends on blre_pkg,
// blre_ifs, blre_line_store, blre_run_logic and the defines header.
//
//   channel   dir   payload                                  handshake
//   req_if    in    pixel                                    valid/ready
//   rsp_if    out   start_row, start_col, end_row, end_col   valid/ready
//   csr_*     in    csr_index, csr_wdata                     csr_we
//
// One pixel beat per cycle; a result passes the working register, then
// the result register. The rate is set by the single line-store port
// pair: one read at accept, one write when the pixel leaves the working
// register. After reset all MAX_WIDTH line-store entries are swept;
// req_if.ready stays low meanwhile. A stalled result holds the working
// register, and a full working register holds off the next pixel beat.
`include "binary_line_run_extractor_unit_defines.svh"

module binary_line_run_extractor_unit #(
   parameter int MAX_WIDTH  = blre_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = blre_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   blre_req_if.sink                    req_if,
   blre_rsp_if.source                  rsp_if,
   input  logic                        csr_we,
   input  logic [blre_pkg::IDX_W-1:0]  csr_index,
   input  logic [blre_pkg::CFG_W-1:0]  csr_wdata
);
   import blre_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int SW = RW + 1;
   localparam logic [CW-1:0] COL_LAST_RST = CW'(last_index(SIZE_RST, MAX_WIDTH));
   localparam logic [RW-1:0] ROW_LAST_RST = RW'(last_index(SIZE_RST, MAX_HEIGHT));

   mode_type         mode_ff;
   logic [CW-1:0]    col_last_ff;
   logic [RW-1:0]    row_last_ff;
   logic [CW-1:0]    cfg_col_last;
   logic [RW-1:0]    cfg_row_last;

   logic [CW-1:0]    col_cnt_ff;
   logic [RW-1:0]    row_cnt_ff;
   logic [CW-1:0]    col_now;
   logic [RW-1:0]    row_now;
   logic             last_col;
   logic             last_row;
   logic [CW-1:0]    rd_addr;

   logic             s1_valid_ff;
   pix_ctl_type      s1_ctl_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [RW-1:0]    s1_row_ff;
   logic             s1_fire;
   logic             req_fire;

   logic             row_run_active_ff;
   logic [CW-1:0]    row_run_start_ff;
   logic             hold_active_ff;
   logic [RW-1:0]    hold_start_ff;

   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_start_row_ff;
   logic [OUT_W-1:0] rsp_start_col_ff;
   logic [OUT_W-1:0] rsp_end_row_ff;
   logic [OUT_W-1:0] rsp_end_col_ff;

   logic [SW-1:0]    rd_data;
   logic             clear_busy;
   logic             store_we;

   step_ctl_type     step_ctl;
   logic [RW-1:0]    store_start;
   logic [CW-1:0]    row_run_start_in;
   logic [OUT_W-1:0] res_start_row;
   logic [OUT_W-1:0] res_start_col;
   logic [OUT_W-1:0] res_end_row;
   logic [OUT_W-1:0] res_end_col;

   // Clamp size writes to a last index
   always_comb begin
      cfg_col_last = CW'(last_index(csr_wdata, MAX_WIDTH));
      cfg_row_last = RW'(last_index(csr_wdata, MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HORIZ;
         col_last_ff <= COL_LAST_RST;
         row_last_ff <= ROW_LAST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_ff     <= mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_WIDTH:  col_last_ff <= cfg_col_last;
            CSR_HEIGHT: row_last_ff <= cfg_row_last;
            default: ;
         endcase
      end
   end

   // Handshake: the working register moves when the result slot frees up
   always_comb begin
      s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
      req_if.ready  = !clear_busy && (!s1_valid_ff || s1_fire);
      req_fire      = req_if.valid && req_if.ready;
   end

   // Clamp the position to the current image size
   always_comb begin
      last_col = (col_cnt_ff >= col_last_ff);
      last_row = (row_cnt_ff >= row_last_ff);
      col_now  = last_col ? col_last_ff : col_cnt_ff;
      row_now  = last_row ? row_last_ff : row_cnt_ff;
      if ((mode_ff == MODE_DIAG_LEFT) && !last_col) begin
         rd_addr = col_now + 1'b1;
      end else begin
         rd_addr = col_now;
      end
   end

   // Advance the raster position on each pixel beat
   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (req_fire) begin
         if (last_col) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= last_row ? '0 : row_now + 1'b1;
         end else begin
            col_cnt_ff <= col_now + 1'b1;
            row_cnt_ff <= row_now;
         end
      end
   end

   // Working register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff.pixel    <= req_if.pixel;
         s1_ctl_ff.last_col <= last_col;
         s1_ctl_ff.last_row <= last_row;
         s1_col_ff          <= col_now;
         s1_row_ff          <= row_now;
      end
   end

   blre_line_store #(
      .DEPTH (MAX_WIDTH),
      .DW    (SW)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (store_we),
      .wr_addr    (s1_col_ff),
      .wr_data    ({step_ctl.store_active, store_start}),
      .rd_en      (req_fire),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   blre_run_logic #(
      .CW (CW),
      .RW (RW)
   ) u_logic (
      .mode         (mode_ff),
      .pix_ctl      (s1_ctl_ff),
      .row          (s1_row_ff),
      .col          (s1_col_ff),
      .rd_active    (rd_data[SW-1]),
      .rd_start     (rd_data[RW-1:0]),
      .hold_active  (hold_active_ff),
      .hold_start   (hold_start_ff),
      .row_active   (row_run_active_ff),
      .row_start    (row_run_start_ff),
      .step_ctl     (step_ctl),
      .store_start  (store_start),
      .row_start_in (row_run_start_in),
      .start_row    (res_start_row),
      .start_col    (res_start_col),
      .end_row      (res_end_row),
      .end_col      (res_end_col)
   );

   assign store_we = s1_fire && step_ctl.store_we;

   // Open horizontal run and the diagonal one-entry delay
   always_ff @(posedge clock) begin
      if (reset) begin
         row_run_active_ff <= 1'b0;
         hold_active_ff    <= 1'b0;
      end else if (s1_fire) begin
         row_run_active_ff <= step_ctl.row_active;
         if (mode_ff == MODE_DIAG_RIGHT) begin
            hold_active_ff <= rd_data[SW-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         row_run_start_ff <= row_run_start_in;
         if (mode_ff == MODE_DIAG_RIGHT) begin
            hold_start_ff <= rd_data[RW-1:0];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (s1_fire && step_ctl.emit) || (rsp_valid_ff && !rsp_if.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && step_ctl.emit) begin
         rsp_start_row_ff <= res_start_row;
         rsp_start_col_ff <= res_start_col;
         rsp_end_row_ff   <= res_end_row;
         rsp_end_col_ff   <= res_end_col;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.start_row = rsp_start_row_ff;
   assign rsp_if.start_col = rsp_start_col_ff;
   assign rsp_if.end_row   = rsp_end_row_ff;
   assign rsp_if.end_col   = rsp_end_col_ff;

   // Checks
   `BLRE_ASSERT_NR(a_reset_state, clock, reset |=> (clear_busy && !s1_valid_ff && !rsp_valid_ff))
   `BLRE_ASSERT(a_stall_holds, clock, reset, (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff)))
   `BLRE_ASSERT(a_store_mode, clock, reset, store_we |-> (mode_ff != MODE_HORIZ))
   `BLRE_ASSERT(a_result_source, clock, reset, $rose(rsp_valid_ff) |-> $past(s1_fire))

endmodule

// ===== sim/tb_binary_line_run_extractor_unit.sv =====
// Self-checking bench for binary_line_run_extractor_unit: pixel beats in, run beats out.
// Depends on blre_pkg, blre_ifs and the unit's RTL. Runs are predicted per accepted
// pixel and checked in order against the result channel.
`timescale 1ns / 100ps

module tb_binary_line_run_extractor_unit;
   import blre_pkg::*;

   localparam int unsigned MAX_COLS      = 1024;
   localparam int unsigned MAX_ROWS      = 1024;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          RANDOM_ITEMS  = 1150;

   typedef struct packed {
      logic [OUT_W-1:0] start_row;
      logic [OUT_W-1:0] start_col;
      logic [OUT_W-1:0] end_row;
      logic [OUT_W-1:0] end_col;
   } run_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   csr_index_type    csr_index;
   logic [CFG_W-1:0] csr_wdata;

   blre_req_if pix_bus ();
   blre_rsp_if run_bus ();

   binary_line_run_extractor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (pix_bus),
      .rsp_if    (run_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pixels waiting to be sent, runs waiting to be seen
   bit      pending_pixels [$];
   run_type expected_runs [$];

   // Predictor copy of registers and state
   mode_type         cfg_mode;
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;
   int unsigned      cur_row;
   int unsigned      cur_col;
   int unsigned      row_start;
   bit               row_open;
   logic [9:0]       col_start [0:MAX_COLS-1];
   bit               col_open [0:MAX_COLS-1];
   logic [9:0]       hold_start;
   bit               hold_open;

   // Bench control
   bit src_gap_en;
   bit stall_en;
   bit long_hold_go;
   int gap_left;
   int stall_left;
   bit long_hold_done;
   int fail_count;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned size_in_use(input logic [CFG_W-1:0] v,
                                               input int unsigned cap);
      if (v == '0) return 1;
      if (int'(v) > cap) return cap;
      return 32'(v);
   endfunction

   function automatic run_type run_of(input int unsigned sr, input int unsigned sc,
                                      input int unsigned er, input int unsigned ec);
      return '{start_row: 10'(sr), start_col: 10'(sc), end_row: 10'(er), end_col: 10'(ec)};
   endfunction

   // Append one pixel to the send queue
   task automatic queue_pixel(input bit px);
      pending_pixels = {pending_pixels, px};
   endtask

   // Append one run to the expectation queue
   task automatic queue_run(input run_type rr);
      expected_runs = {expected_runs, rr};
   endtask

   // Advance the predictor by one pixel and queue the run it closes, if any
   task automatic trace_pixel(input bit px);
      int unsigned w, h, r, c, st, in_st, er, ec, sc;
      bit last_col, last_row, in_act, at_edge, right;
      w = size_in_use(cfg_width, MAX_COLS);
      h = size_in_use(cfg_height, MAX_ROWS);
      r = cur_row;
      c = cur_col;
      last_col = (c >= w - 1);
      if (last_col) c = w - 1;
      last_row = (r >= h - 1);
      if (last_row) r = h - 1;

      case (cfg_mode)
         MODE_HORIZ: begin
            // a new row drops any run left open by the previous one
            if (c == 0) row_open = 1'b0;
            if (px) begin
               if (!row_open) begin
                  row_open  = 1'b1;
                  row_start = c;
               end
               if (last_col) begin
                  if (row_start < c) queue_run(run_of(r, row_start, r, c));
                  row_open = 1'b0;
               end
            end else begin
               if (row_open && row_start + 1 < c)
                  queue_run(run_of(r, row_start, r, c - 1));
               row_open = 1'b0;
            end
         end
         MODE_VERT: begin
            in_act = (r > 0) && col_open[c];
            st     = 32'(col_start[c]);
            if (px) begin
               if (!in_act) st = r;
               if (last_row) begin
                  if (st < r) queue_run(run_of(st, c, r, c));
                  col_open[c] = 1'b0;
               end else begin
                  col_open[c]  = 1'b1;
                  col_start[c] = 10'(st);
               end
            end else begin
               if (in_act && st + 1 < r) queue_run(run_of(st, c, r - 1, c));
               col_open[c] = 1'b0;
            end
         end
         default: begin
            right = (cfg_mode == MODE_DIAG_RIGHT);
            if (right) begin
               // the upper-left neighbor comes through a one-entry delay
               in_act    = (r > 0) && (c > 0) && hold_open;
               in_st     = 32'(hold_start);
               hold_open  = col_open[c];
               hold_start = col_start[c];
               at_edge   = last_row || last_col;
            end else begin
               in_act  = (r > 0) && !last_col && col_open[c + 1];
               in_st   = last_col ? 0 : 32'(col_start[c + 1]);
               at_edge = last_row || (c == 0);
            end
            if (px) begin
               st = in_act ? in_st : r;
               if (at_edge) begin
                  if (st < r) begin
                     sc = right ? c - (r - st) : c + (r - st);
                     queue_run(run_of(st, sc, r, c));
                  end
                  col_open[c] = 1'b0;
               end else begin
                  col_open[c]  = 1'b1;
                  col_start[c] = 10'(st);
               end
            end else begin
               if (in_act && in_st + 1 < r) begin
                  er = r - 1;
                  ec = right ? c - 1 : c + 1;
                  sc = right ? ec - (er - in_st) : ec + (er - in_st);
                  queue_run(run_of(in_st, sc, er, ec));
               end
               col_open[c] = 1'b0;
            end
         end
      endcase

      // advance raster position
      if (last_col) begin
         cur_col = 0;
         cur_row = last_row ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
         cur_row = r;
      end
   endtask

   // Pixel driver: hold a beat until taken, insert gap bursts, feed from the queue
   always @(posedge clock) begin
      if (reset) begin
         pix_bus.valid <= 1'b0;
         pix_bus.pixel <= 1'b0;
         gap_left      <= 0;
      end else begin
         if (pix_bus.valid && pix_bus.ready) begin
            trace_pixel(pix_bus.pixel);
         end
         if (pix_bus.valid && !pix_bus.ready) begin
            // hold the offered beat
         end else if (gap_left > 0) begin
            gap_left      <= gap_left - 1;
            pix_bus.valid <= 1'b0;
         end else if (pending_pixels.size() != 0 && src_gap_en
                      && $urandom_range(0, 7) == 0) begin
            gap_left      <= int'($urandom_range(1, 17)) - 1;
            pix_bus.valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            pix_bus.valid <= 1'b1;
            pix_bus.pixel <= pending_pixels.pop_front();
         end else begin
            pix_bus.valid <= 1'b0;
         end
      end
   end

   // Result ready: random stall bursts, plus one long hold-off while pixels keep coming
   always @(posedge clock) begin
      if (reset) begin
         run_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (!long_hold_done && long_hold_go) begin
         long_hold_done <= 1'b1;
         stall_left     <= 299;
         run_bus.ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left    <= stall_left - 1;
         run_bus.ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 9) == 0) begin
         stall_left    <= int'($urandom_range(1, 17)) - 1;
         run_bus.ready <= 1'b0;
      end else begin
         run_bus.ready <= 1'b1;
      end
   end

   // Result monitor: compare each accepted run beat with the oldest expectation
   always @(posedge clock) begin
      run_type exp_run;
      if (!reset && run_bus.valid && run_bus.ready) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected run beat %0d,%0d -> %0d,%0d", run_bus.start_row,
                   run_bus.start_col, run_bus.end_row, run_bus.end_col);
            fail_count = fail_count + 1;
         end else begin
            exp_run = expected_runs.pop_front();
            if (run_bus.start_row !== exp_run.start_row) begin
               $error("start_row expected %0d actual %0d", exp_run.start_row,
                      run_bus.start_row);
               fail_count = fail_count + 1;
            end
            if (run_bus.start_col !== exp_run.start_col) begin
               $error("start_col expected %0d actual %0d", exp_run.start_col,
                      run_bus.start_col);
               fail_count = fail_count + 1;
            end
            if (run_bus.end_row !== exp_run.end_row) begin
               $error("end_row expected %0d actual %0d", exp_run.end_row, run_bus.end_row);
               fail_count = fail_count + 1;
            end
            if (run_bus.end_col !== exp_run.end_col) begin
               $error("end_col expected %0d actual %0d", exp_run.end_col, run_bus.end_col);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Write all three registers on consecutive edges; the block must be idle
   task automatic set_config(input mode_type m, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] h);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= {9'($urandom), m};
      @(posedge clock);
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_mode   = m;
      cfg_width  = w;
      cfg_height = h;
   endtask

   // Queue the low n bits of a pattern, most significant first
   task automatic queue_bits(input logic [31:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) queue_pixel(bits[i]);
   endtask

   task automatic queue_random(input int n, input int density_pct);
      for (int i = 0; i < n; i++) queue_pixel($urandom_range(0, 99) < density_pct);
   endtask

   // Stop sending until every beat is taken and every run has come back
   task automatic wait_all_done();
      do @(posedge clock);
      while (pending_pixels.size() != 0 || pix_bus.valid || expected_runs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase: random mode and sizes (mostly small), random density
   task automatic random_phase(output int n);
      mode_type         m;
      logic [CFG_W-1:0] w;
      logic [CFG_W-1:0] h;
      int               dens;
      m = mode_type'($urandom_range(0, 3));
      case ($urandom_range(0, 11))
         0:       w = '0;
         1:       w = 11'($urandom_range(13, 2047));
         default: w = 11'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 11))
         0:       h = '0;
         1:       h = 11'($urandom_range(13, 2047));
         default: h = 11'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 3))
         0:       dens = 30;
         1:       dens = 95;
         default: dens = 65;
      endcase
      n = int'($urandom_range(20, 100));
      set_config(m, w, h);
      queue_random(n, dens);
      wait_all_done();
   endtask

   initial begin
      int n;
      int sent;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_MODE;
      csr_wdata       = '0;
      pix_bus.valid   = 1'b0;
      pix_bus.pixel   = 1'b0;
      run_bus.ready   = 1'b0;
      src_gap_en      = 1'b1;
      stall_en        = 1'b1;
      long_hold_go    = 1'b0;
      long_hold_done  = 1'b0;
      fail_count      = 0;
      cycle_count     = 0;
      cfg_mode        = MODE_HORIZ;
      cfg_width       = SIZE_RST;
      cfg_height      = SIZE_RST;
      cur_row         = 0;
      cur_col         = 0;
      row_start       = 0;
      row_open        = 1'b0;
      hold_start      = '0;
      hold_open       = 1'b0;
      for (int i = 0; i < MAX_COLS; i++) begin
         col_start[i] = '0;
         col_open[i]  = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: each mode over one whole small frame
      // horizontal: run closed by the right edge, run closed by a zero
      set_config(MODE_HORIZ, 11'd4, 11'd2);
      queue_bits(32'b1111_0110, 8);
      wait_all_done();
      // vertical: run closed by the bottom edge, run closed by a zero
      set_config(MODE_VERT, 11'd2, 11'd3);
      queue_bits(32'b11_11_10, 6);
      wait_all_done();
      // diagonals: one two-pixel run each
      set_config(MODE_DIAG_RIGHT, 11'd2, 11'd2);
      queue_bits(32'b10_01, 4);
      wait_all_done();
      set_config(MODE_DIAG_LEFT, 11'd2, 11'd2);
      queue_bits(32'b01_10, 4);
      wait_all_done();
      // single pixels give nothing; zero sizes count as one
      set_config(MODE_HORIZ, 11'd3, 11'd1);
      queue_bits(32'b010, 3);
      wait_all_done();
      set_config(MODE_VERT, 11'd0, 11'd0);
      queue_bits(32'b1, 1);
      wait_all_done();

      // Random phases, small sizes mostly
      sent = 0;
      while (sent < RANDOM_ITEMS / 2) begin
         src_gap_en = ($urandom_range(0, 3) != 0);
         stall_en   = ($urandom_range(0, 3) != 0);
         random_phase(n);
         sent += n;
      end

      // Back-pressure: a run per row while the result side holds off
      set_config(MODE_HORIZ, 11'd4, 11'd2);
      long_hold_go = 1'b1;
      queue_bits(32'hFFFF_FFFF, 32);
      wait_all_done();

      while (sent < RANDOM_ITEMS - 150) begin
         src_gap_en = ($urandom_range(0, 3) != 0);
         stall_en   = ($urandom_range(0, 3) != 0);
         random_phase(n);
         sent += n;
      end

      // Closing stretch at full rate on both sides
      src_gap_en = 1'b0;
      stall_en   = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         random_phase(n);
         sent += n;
      end

      wait_all_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_runs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/blre_pkg.sv
sv/blre_ifs.sv
sv/blre_line_store.sv
sv/blre_run_logic.sv
sv/binary_line_run_extractor_unit.sv
sim/tb_binary_line_run_extractor_unit.sv
